>>> design/tesch_pkg.sv
package tesch_pkg;

  localparam int unsigned DEFAULT_NUM_TIMERS = 16;
  localparam int unsigned DEFAULT_TIME_WIDTH = 32;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned PERIOD_W = 31;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [ID_W-1:0]     timer_id;
    logic [PERIOD_W-1:0] interval;
    logic                repeating;
  } tesch_req_t;

  typedef struct packed {
    logic [ID_W-1:0] expired_id;
    logic            last;
  } tesch_rsp_t;

  // Outcome of one pass of an entry through the compare unit.
  typedef struct packed {
    logic expired;
    logic better;
  } tesch_cmp_t;

endpackage

>>> design/tesch_ram.sv
module tesch_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/tesch_key.sv
module tesch_key #(
  parameter int unsigned TIME_WIDTH = tesch_pkg::DEFAULT_TIME_WIDTH
) (
  input  logic [TIME_WIDTH-1:0] expiry_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic [TIME_WIDTH-1:0] best_key_i,
  output logic [TIME_WIDTH-1:0] key_o,
  output tesch_pkg::tesch_cmp_t res_o
);

  logic [TIME_WIDTH-1:0] diff;

  // The signed distance to expiry, biased by half the range so that it
  // orders as an unsigned number.
  assign diff  = expiry_i - now_i;
  assign key_o = {~diff[TIME_WIDTH-1], diff[TIME_WIDTH-2:0]};

  assign res_o.expired = (diff == '0) || diff[TIME_WIDTH-1];
  assign res_o.better  = key_o < best_key_i;

endmodule

>>> design/timer_expiry_scheduler_unit.sv
// Timer table with a time base that advances by one on each tick. Add and
// remove transactions keep busy low. A tick transaction raises busy
// and runs a selection sort over the table: each pass streams all NUM_TIMERS
// entries from the entry RAM through one compare unit, then services the
// earliest expired timer found. Passes run one after another, one per report
// plus a final pass that finds none, as the entry RAM has a single read port.
// Reports leave one per pass in report order, each valid for exactly one cycle
// on result_valid_o, with last set on the final report of the tick; the
// receiver cannot stall them. A tick with no expired timer produces no report.
module timer_expiry_scheduler_unit #(
  parameter int unsigned NUM_TIMERS = tesch_pkg::DEFAULT_NUM_TIMERS,
  parameter int unsigned TIME_WIDTH = tesch_pkg::DEFAULT_TIME_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  tesch_pkg::tesch_req_t req_i,
  output logic                  result_valid_o,
  output tesch_pkg::tesch_rsp_t result_o
);

  localparam int unsigned IDX_W   = $clog2(NUM_TIMERS);
  localparam int unsigned CNT_W   = $clog2(NUM_TIMERS + 1);
  localparam int unsigned ENTRY_W = TIME_WIDTH + tesch_pkg::PERIOD_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PASS_END
  } state_e;

  state_e                          state_q, state_d;
  logic [TIME_WIDTH-1:0]           now_q, now_d;
  logic [NUM_TIMERS-1:0]           armed_q, armed_d;
  logic [NUM_TIMERS-1:0]           done_q, done_d;
  logic [CNT_W-1:0]                rd_cnt_q, rd_cnt_d;
  logic                            cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]                cmp_idx_q, cmp_idx_d;
  logic                            found_q, found_d;
  logic [IDX_W-1:0]                best_idx_q, best_idx_d;
  logic [TIME_WIDTH-1:0]           best_key_q, best_key_d;
  logic [tesch_pkg::PERIOD_W-1:0]  best_period_q, best_period_d;
  logic                            best_rep_q, best_rep_d;
  logic                            held_q, held_d;
  logic [IDX_W-1:0]                held_idx_q, held_idx_d;
  logic                            result_valid_q, result_valid_d;
  tesch_pkg::tesch_rsp_t           result_q, result_d;

  logic                            accept;
  logic                            id_ok;
  logic [IDX_W-1:0]                req_idx;
  logic                            issuing;

  logic                            ram_we;
  logic [IDX_W-1:0]                ram_waddr;
  logic [ENTRY_W-1:0]              ram_wdata;
  logic [ENTRY_W-1:0]              ram_rdata;
  logic [tesch_pkg::PERIOD_W-1:0]  add_amount;
  logic                            add_rep;
  logic [TIME_WIDTH-1:0]           new_expiry;

  logic [TIME_WIDTH-1:0]           rd_expiry;
  logic [tesch_pkg::PERIOD_W-1:0]  rd_period;
  logic                            rd_rep;
  logic [TIME_WIDTH-1:0]           cand_key;
  tesch_pkg::tesch_cmp_t           cand_res;
  logic                            cand_take;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign id_ok   = 32'(req_i.timer_id) < NUM_TIMERS;
  assign req_idx = IDX_W'(req_i.timer_id);
  assign issuing = (state_q == ST_SCAN) && (rd_cnt_q < CNT_W'(NUM_TIMERS));

  assign rd_expiry = ram_rdata[TIME_WIDTH-1:0];
  assign rd_period = ram_rdata[TIME_WIDTH +: tesch_pkg::PERIOD_W];
  assign rd_rep    = ram_rdata[ENTRY_W-1];

  // One adder serves both an add and the re-arm of a repeating timer.
  assign add_amount = (state_q == ST_IDLE) ? req_i.interval : best_period_q;
  assign add_rep    = (state_q == ST_IDLE) ? req_i.repeating : best_rep_q;
  assign new_expiry = now_q + TIME_WIDTH'(add_amount);
  assign ram_wdata  = {add_rep, add_amount, new_expiry};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx_q;
    if (state_q == ST_IDLE) begin
      ram_waddr = req_idx;
      ram_we    = accept && (req_i.op == tesch_pkg::OP_ADD) && id_ok;
    end else if (state_q == ST_PASS_END) begin
      ram_we = found_q && best_rep_q;
    end
  end

  tesch_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_TIMERS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  tesch_key #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_key (
    .expiry_i   (rd_expiry),
    .now_i      (now_q),
    .best_key_i (best_key_q),
    .key_o      (cand_key),
    .res_o      (cand_res)
  );

  // Slots already reported this tick are skipped; a strict compare keeps the
  // lower slot on equal keys.
  assign cand_take = cmp_vld_q && armed_q[cmp_idx_q] && !done_q[cmp_idx_q] &&
                     cand_res.expired && (!found_q || cand_res.better);

  always_comb begin
    state_d        = state_q;
    now_d          = now_q;
    armed_d        = armed_q;
    done_d         = done_q;
    rd_cnt_d       = rd_cnt_q;
    cmp_vld_d      = issuing;
    cmp_idx_d      = rd_cnt_q[IDX_W-1:0];
    found_d        = found_q;
    best_idx_d     = best_idx_q;
    best_key_d     = best_key_q;
    best_period_d  = best_period_q;
    best_rep_d     = best_rep_q;
    held_d         = held_q;
    held_idx_d     = held_idx_q;
    result_valid_d = 1'b0;
    result_d       = result_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.op)
            tesch_pkg::OP_ADD: begin
              if (id_ok) begin
                armed_d[req_idx] = 1'b1;
              end
            end
            tesch_pkg::OP_REMOVE: begin
              if (id_ok) begin
                armed_d[req_idx] = 1'b0;
              end
            end
            tesch_pkg::OP_TICK: begin
              now_d    = now_q + TIME_WIDTH'(1);
              done_d   = '0;
              rd_cnt_d = '0;
              found_d  = 1'b0;
              held_d   = 1'b0;
              state_d  = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          rd_cnt_d = rd_cnt_q + CNT_W'(1);
        end
        if (cand_take) begin
          found_d       = 1'b1;
          best_idx_d    = cmp_idx_q;
          best_key_d    = cand_key;
          best_period_d = rd_period;
          best_rep_d    = rd_rep;
        end
        if (cmp_vld_q && (cmp_idx_q == IDX_W'(NUM_TIMERS - 1))) begin
          state_d = ST_PASS_END;
        end
      end
      ST_PASS_END: begin
        // The previous report goes out once it is known whether more follow.
        result_d.expired_id = tesch_pkg::ID_W'(held_idx_q);
        result_d.last       = !found_q;
        result_valid_d      = held_q;
        if (found_q) begin
          done_d[best_idx_q] = 1'b1;
          if (!best_rep_q) begin
            armed_d[best_idx_q] = 1'b0;
          end
          held_d     = 1'b1;
          held_idx_d = best_idx_q;
          found_d    = 1'b0;
          rd_cnt_d   = '0;
          state_d    = ST_SCAN;
        end else begin
          held_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      now_q          <= '0;
      armed_q        <= '0;
      done_q         <= '0;
      rd_cnt_q       <= '0;
      cmp_vld_q      <= 1'b0;
      found_q        <= 1'b0;
      held_q         <= 1'b0;
      result_valid_q <= 1'b0;
      cmp_idx_q      <= '0;
      best_idx_q     <= '0;
      best_key_q     <= '0;
      best_period_q  <= '0;
      best_rep_q     <= 1'b0;
      held_idx_q     <= '0;
      result_q       <= '0;
    end else begin
      state_q        <= state_d;
      now_q          <= now_d;
      armed_q        <= armed_d;
      done_q         <= done_d;
      rd_cnt_q       <= rd_cnt_d;
      cmp_vld_q      <= cmp_vld_d;
      found_q        <= found_d;
      held_q         <= held_d;
      result_valid_q <= result_valid_d;
      cmp_idx_q      <= cmp_idx_d;
      best_idx_q     <= best_idx_d;
      best_key_q     <= best_key_d;
      best_period_q  <= best_period_d;
      best_rep_q     <= best_rep_d;
      held_idx_q     <= held_idx_d;
      result_q       <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

`ifndef SYNTHESIS
  a_last_ends_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |-> state_q == ST_IDLE)
    else $error("final report did not end the tick");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy)
    else $error("non-final report while idle");

  a_report_from_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == ST_PASS_END)
    else $error("report outside a pass end");

  a_tick_raises_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.op == tesch_pkg::OP_TICK |=> busy)
    else $error("tick did not start a scan");

  a_serviced_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PASS_END && found_q |=> done_q[$past(best_idx_q)])
    else $error("serviced timer not marked as reported");
`endif

endmodule

>>> tb/timer_expiry_scheduler_unit_tb.sv
`timescale 1ns / 1ps

module timer_expiry_scheduler_unit_tb;

  localparam int unsigned NT = tesch_pkg::DEFAULT_NUM_TIMERS;
  localparam int unsigned TW = tesch_pkg::DEFAULT_TIME_WIDTH;
  localparam int unsigned PASS_CYCLES = NT + 2;
  localparam int unsigned RANDOM_ITEMS = 325;
  localparam logic [tesch_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [tesch_pkg::PERIOD_W-1:0] IVL_MAX = '1;

  typedef struct {
    tesch_pkg::tesch_req_t      rq;
    bit                         typed;
    int unsigned                n_rpt;
    logic [tesch_pkg::ID_W-1:0] id_a;
    logic [tesch_pkg::ID_W-1:0] id_b;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  result_valid_o;
  tesch_pkg::tesch_req_t req_i;
  tesch_pkg::tesch_rsp_t result_o;

  timer_expiry_scheduler_unit #(
    .NUM_TIMERS(NT),
    .TIME_WIDTH(TW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // Our own copy of the timer table.
  logic [TW-1:0]                  now_t;
  logic [TW-1:0]                  due_at [NT];
  logic [tesch_pkg::PERIOD_W-1:0] period_t [NT];
  logic                           rearm_t [NT];
  logic                           live_t [NT];

  tesch_pkg::tesch_rsp_t tick_reports [$];
  tesch_pkg::tesch_rsp_t typed_reports [$];
  tesch_pkg::tesch_rsp_t pending_reports [$];
  dir_row_t              directed_rows [$];
  tesch_pkg::tesch_rsp_t want;
  int unsigned           mismatch_count;
  bit                    quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // Applies one transaction to the table and leaves its expiry reports in tick_reports.
  function automatic void service_timers(input tesch_pkg::tesch_req_t rq);
    logic [NT-1:0]         hit;
    logic [TW-1:0]         diff;
    logic [TW-1:0]         key;
    logic [TW-1:0]         best_key;
    int                    best;
    int                    n_picked;
    int                    picked [NT];
    bit                    done;
    tesch_pkg::tesch_rsp_t rpt;
    tick_reports.delete();
    case (rq.op)
      tesch_pkg::OP_ADD: begin
        period_t[rq.timer_id] = rq.interval;
        rearm_t[rq.timer_id] = rq.repeating;
        due_at[rq.timer_id] = now_t + TW'(rq.interval);
        live_t[rq.timer_id] = 1'b1;
      end
      tesch_pkg::OP_REMOVE: begin
        live_t[rq.timer_id] = 1'b0;
      end
      tesch_pkg::OP_TICK: begin
        now_t = now_t + 1'b1;
        for (int s = 0; s < NT; s++) begin
          diff = due_at[s] - now_t;
          hit[s] = live_t[s] && (diff == '0 || diff[TW-1]);
        end
        // Selection by signed distance to now; flipping the sign bit makes it sort unsigned.
        n_picked = 0;
        done = 1'b0;
        while (!done) begin
          best = -1;
          best_key = '0;
          for (int s = 0; s < NT; s++) begin
            if (hit[s]) begin
              diff = due_at[s] - now_t;
              key = {~diff[TW-1], diff[TW-2:0]};
              if (best < 0 || key < best_key) begin
                best = s;
                best_key = key;
              end
            end
          end
          if (best < 0) begin
            done = 1'b1;
          end else begin
            hit[best] = 1'b0;
            picked[n_picked] = best;
            n_picked++;
          end
        end
        // Re-arming happens only after selection, so a repeating timer fires once per tick.
        for (int k = 0; k < n_picked; k++) begin
          rpt.expired_id = tesch_pkg::ID_W'(picked[k]);
          rpt.last = (k == n_picked - 1);
          tick_reports = {tick_reports, rpt};
          if (rearm_t[picked[k]]) begin
            due_at[picked[k]] = now_t + TW'(period_t[picked[k]]);
          end else begin
            live_t[picked[k]] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic add_row(input logic [tesch_pkg::OP_W-1:0] op, input int unsigned id,
                         input logic [tesch_pkg::PERIOD_W-1:0] ivl, input logic rep,
                         input bit typed, input int unsigned n_rpt,
                         input int unsigned id_a, input int unsigned id_b);
    dir_row_t row;
    row.rq.op = op;
    row.rq.timer_id = tesch_pkg::ID_W'(id);
    row.rq.interval = ivl;
    row.rq.repeating = rep;
    row.typed = typed;
    row.n_rpt = n_rpt;
    row.id_a = tesch_pkg::ID_W'(id_a);
    row.id_b = tesch_pkg::ID_W'(id_b);
    directed_rows = {directed_rows, row};
  endtask

  // Holds start high until the transaction is taken, then books its expected reports.
  task automatic issue(input tesch_pkg::tesch_req_t rq, input bit use_typed);
    req_i <= rq;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    service_timers(rq);
    if (use_typed) begin
      foreach (typed_reports[k]) pending_reports = {pending_reports, typed_reports[k]};
    end else begin
      foreach (tick_reports[k]) pending_reports = {pending_reports, tick_reports[k]};
    end
  endtask

  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (quiet || r < 55) n = 0;
    else if (r < 92) n = $urandom_range(3, 1);
    else n = $urandom_range(60, 10);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: expired_id %0d last %0b",
               result_o.expired_id, result_o.last);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        if (result_o.expired_id !== want.expired_id) begin
          $error("expired_id: expected %0d, got %0d", want.expired_id, result_o.expired_id);
          mismatch_count++;
        end
        if (result_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result_o.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    tesch_pkg::tesch_req_t rq;
    tesch_pkg::tesch_rsp_t rpt;
    int unsigned           sent;
    int unsigned           r;
    int unsigned           k;
    int unsigned           drain;
    rst_ni <= 1'b0;
    start <= 1'b0;
    req_i <= '0;
    mismatch_count = 0;
    quiet = 1'b0;
    sent = 0;
    now_t = '0;
    for (int s = 0; s < NT; s++) begin
      live_t[s] = 1'b0;
      due_at[s] = '0;
      period_t[s] = '0;
      rearm_t[s] = 1'b0;
    end

    // Directed rows: op, slot, interval, repeat, typed, report count, first, second.
    add_row(tesch_pkg::OP_TICK,   0, 0,       0, 1, 0, 0, 0);
    add_row(tesch_pkg::OP_ADD,    0, 1,       0, 1, 0, 0, 0);
    add_row(tesch_pkg::OP_TICK,   0, 0,       0, 1, 1, 0, 0);
    add_row(tesch_pkg::OP_TICK,   0, 0,       0, 1, 0, 0, 0);
    add_row(tesch_pkg::OP_ADD,   15, 0,       1, 1, 0, 0, 0);
    add_row(tesch_pkg::OP_TICK,   0, 0,       0, 1, 1, 15, 0);
    add_row(tesch_pkg::OP_TICK,   0, 0,       0, 1, 1, 15, 0);
    add_row(tesch_pkg::OP_REMOVE, 15, 0,      0, 1, 0, 0, 0);
    add_row(tesch_pkg::OP_TICK,   0, 0,       0, 1, 0, 0, 0);
    add_row(tesch_pkg::OP_REMOVE, 3, 0,       0, 1, 0, 0, 0);
    add_row(OP_UNUSED,            9, IVL_MAX, 1, 1, 0, 0, 0);
    add_row(tesch_pkg::OP_TICK,   0, 0,       0, 1, 0, 0, 0);
    add_row(tesch_pkg::OP_ADD,    7, IVL_MAX, 1, 1, 0, 0, 0);
    add_row(tesch_pkg::OP_ADD,    4, 1,       0, 1, 0, 0, 0);
    add_row(tesch_pkg::OP_ADD,    2, 1,       0, 1, 0, 0, 0);
    add_row(tesch_pkg::OP_TICK,   0, 0,       0, 1, 2, 2, 4);
    add_row(tesch_pkg::OP_ADD,    9, 3,       1, 0, 0, 0, 0);
    add_row(tesch_pkg::OP_ADD,    9, 1,       0, 0, 0, 0, 0);
    add_row(tesch_pkg::OP_ADD,   12, 0,       0, 0, 0, 0, 0);
    add_row(tesch_pkg::OP_ADD,    1, 1,       1, 0, 0, 0, 0);
    add_row(tesch_pkg::OP_TICK,   0, 0,       0, 0, 0, 0, 0);
    add_row(tesch_pkg::OP_TICK,   0, 0,       0, 0, 0, 0, 0);
    add_row(tesch_pkg::OP_REMOVE, 7, 0,       0, 0, 0, 0, 0);
    add_row(tesch_pkg::OP_REMOVE, 1, 0,       0, 0, 0, 0, 0);
    add_row(tesch_pkg::OP_TICK,  15, IVL_MAX, 1, 0, 0, 0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      typed_reports.delete();
      if (directed_rows[i].n_rpt > 0) begin
        rpt.expired_id = directed_rows[i].id_a;
        rpt.last = (directed_rows[i].n_rpt == 1);
        typed_reports = {typed_reports, rpt};
      end
      if (directed_rows[i].n_rpt > 1) begin
        rpt.expired_id = directed_rows[i].id_b;
        rpt.last = 1'b1;
        typed_reports = {typed_reports, rpt};
      end
      issue(directed_rows[i].rq, directed_rows[i].typed);
      idle_gap();
    end

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(29) == 0) quiet = ~quiet;
      r = $urandom_range(99);
      rq = '0;
      if (r < 4) begin
        // Arm every slot with an interval of at most two, so that all fall due within the next two ticks.
        for (int s = 0; s < NT; s++) begin
          rq.op = tesch_pkg::OP_ADD;
          rq.timer_id = tesch_pkg::ID_W'(s);
          rq.interval = tesch_pkg::PERIOD_W'($urandom_range(2));
          rq.repeating = 1'($urandom_range(1));
          issue(rq, 1'b0);
          idle_gap();
        end
        sent += NT;
      end else begin
        if (r < 48) rq.op = tesch_pkg::OP_TICK;
        else if (r < 85) rq.op = tesch_pkg::OP_ADD;
        else if (r < 97) rq.op = tesch_pkg::OP_REMOVE;
        else rq.op = OP_UNUSED;
        rq.timer_id = tesch_pkg::ID_W'($urandom_range(NT - 1));
        rq.repeating = 1'($urandom_range(1));
        k = $urandom_range(99);
        if (k < 70) rq.interval = tesch_pkg::PERIOD_W'($urandom_range(12));
        else if (k < 90) rq.interval = tesch_pkg::PERIOD_W'($urandom_range(300, 13));
        else rq.interval = tesch_pkg::PERIOD_W'($urandom());
        issue(rq, 1'b0);
        idle_gap();
        if (rq.op != OP_UNUSED) sent++;
      end
    end
    start <= 1'b0;

    drain = 0;
    while ((pending_reports.size() != 0 || busy) && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (2 * PASS_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (pending_reports.size() != 0) begin
        $error("%0d expected reports never arrived", pending_reports.size());
      end
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
design/tesch_pkg.sv
design/tesch_ram.sv
design/tesch_key.sv
design/timer_expiry_scheduler_unit.sv
tb/timer_expiry_scheduler_unit_tb.sv
